### sv/mcpe_pkg.sv
// Shared types, constants and attribute helpers for the mouse cursor paint engine.
// No dependencies; every other file imports this package.
package mcpe_pkg;

    localparam int DEF_SCREEN_COLUMNS  = 80;
    localparam int DEF_SCREEN_ROWS     = 25;
    localparam int DEF_CELL_SCALE      = 72;
    localparam int DEF_SWATCH_WIDTH    = 4;
    localparam int DEF_PALETTE_ROWS    = 2;
    localparam int DEF_DARK_BACKGROUND = 0;

    localparam int NUM_SWATCHES = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int SPEED_W      = 4;

    // widest internal fields over the whole parameter range
    localparam int ADDR_MAX_W = 13;
    localparam int COL_MAX_W  = 7;
    localparam int ROW_MAX_W  = 6;

    localparam int CELL_ADDR_W = 11;
    localparam int COL_OUT_W   = 7;
    localparam int ROW_OUT_W   = 5;

    localparam logic [2:0] PAINT_COLOR_RESET = 3'd4;
    localparam logic [7:0] HL_MASK           = 8'h88;
    localparam logic [7:0] COLOR_MASK        = 8'h77;

    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_RIGHT = 1;
    localparam int FLAG_XSIGN = 4;
    localparam int FLAG_YSIGN = 5;
    localparam int FLAG_XOVF  = 6;
    localparam int FLAG_YOVF  = 7;

    typedef struct packed {
        logic [7:0] packet_flags;
        logic [7:0] move_x;
        logic [7:0] move_y;
    } packet_word_t;

    typedef struct packed {
        logic [CELL_ADDR_W-1:0] cell_address;
        logic [7:0]             attribute_value;
        logic                   last_write;
        logic [COL_OUT_W-1:0]   cursor_column;
        logic [ROW_OUT_W-1:0]   cursor_row;
        logic [2:0]             chosen_color;
    } result_word_t;

    typedef struct packed {
        logic [ADDR_MAX_W-1:0] addr;
        logic [COL_MAX_W-1:0]  col;
        logic [ROW_MAX_W-1:0]  row;
        logic [2:0]            color;
        logic                  left;
        logic                  paint;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    function automatic logic [7:0] with_highlight(input logic [7:0] a, input logic on);
        return on ? (a | HL_MASK) : (a & COLOR_MASK);
    endfunction

    function automatic logic [7:0] with_color(input logic [7:0] a, input logic [2:0] c);
        return (a & HL_MASK) | {1'b0, c, 1'b0, c};
    endfunction

    function automatic logic [2:0] swatch_of(input logic [COL_MAX_W-1:0] col,
                                             input int sw);
        logic [2:0] c;
        c = 3'd0;
        for (int i = 1; i < NUM_SWATCHES; i++) begin
            if (int'(col) >= i * sw) begin
                c = 3'(i);
            end
        end
        return c;
    endfunction

endpackage

### sv/mcpe_front.sv
// Front end: speed register, canvas cursor update and clamp, cell lookup pipeline,
// palette classification and colour selection. Depends on mcpe_pkg.
module mcpe_front import mcpe_pkg::*; #(
    parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
    parameter int CELL_SCALE     = DEF_CELL_SCALE,
    parameter int SWATCH_WIDTH   = DEF_SWATCH_WIDTH,
    parameter int PALETTE_ROWS   = DEF_PALETTE_ROWS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [SPEED_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  packet_word_t       s_data,
    input  logic               enable,
    input  logic               q_full,
    output q_push_t            q_wr
);

    localparam int CANVAS_W = SCREEN_COLUMNS * CELL_SCALE;
    localparam int CANVAS_H = SCREEN_ROWS * CELL_SCALE;
    localparam int XW       = $clog2(CANVAS_W);
    localparam int YW       = $clog2(CANVAS_H);
    localparam int SH       = (XW > YW) ? XW : YW;
    localparam int RW       = SH + 1;
    localparam int RECIP    = (2 ** SH) / CELL_SCALE;
    localparam int SUM_W    = ((SH > 13) ? SH : 13) + 2;
    localparam int COL_W    = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W    = $clog2(SCREEN_ROWS);
    localparam int ADDR_W   = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);
    localparam int PAL_COLS = SWATCH_WIDTH * NUM_SWATCHES;
    localparam int PAL_ROW0 = SCREEN_ROWS - PALETTE_ROWS;

    localparam logic [XW-1:0] X_RESET = XW'(CANVAS_W / 2);
    localparam logic [YW-1:0] Y_RESET = YW'(CANVAS_H / 2);

    logic [SPEED_W-1:0] speed_reg;
    logic [XW-1:0]      x_reg, x_next;
    logic [YW-1:0]      y_reg, y_next;
    logic [2:0]         color_reg, color_next;

    logic               st1_valid_reg, st1_left_reg, st1_right_reg;
    logic [XW-1:0]      st1_x_reg;
    logic [YW-1:0]      st1_y_reg;
    logic               st2_valid_reg, st2_left_reg, st2_right_reg;
    logic [XW-1:0]      st2_x_reg;
    logic [YW-1:0]      st2_y_reg;
    logic [COL_W-1:0]   st2_qx_reg;
    logic [ROW_W-1:0]   st2_qy_reg;
    logic               st3_valid_reg, st3_left_reg, st3_right_reg;
    logic [COL_W-1:0]   st3_col_reg;
    logic [ROW_W-1:0]   st3_qy_reg;

    logic                    advance, take, overflow, load;
    logic signed [8:0]       dx, dy;
    logic signed [13:0]      px, py;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic [XW+RW-1:0]        x_prod;
    logic [YW+RW-1:0]        y_prod;
    logic [XW-1:0]           x_base, x_rem;
    logic [YW-1:0]           y_base, y_rem;
    logic [COL_W-1:0]        col_next;
    logic [ROW_W-1:0]        qy_next;
    logic [ROW_W-1:0]        row_scr;
    logic                    on_palette;
    logic [ADDR_W-1:0]       cell_addr;

    assign advance  = !st3_valid_reg || !q_full;
    assign s_ready  = advance && enable;
    assign take     = s_valid && s_ready;
    assign overflow = s_data.packet_flags[FLAG_XOVF] || s_data.packet_flags[FLAG_YOVF];
    assign load     = take && !overflow;

    assign dx = $signed({s_data.packet_flags[FLAG_XSIGN], s_data.move_x});
    assign dy = $signed({s_data.packet_flags[FLAG_YSIGN], s_data.move_y});
    assign px = dx * $signed({1'b0, speed_reg});
    assign py = dy * $signed({1'b0, speed_reg});

    always_comb begin
        sum_x = SUM_W'($signed({1'b0, x_reg})) + SUM_W'(px);
        sum_y = SUM_W'($signed({1'b0, y_reg})) + SUM_W'(py);
        if (sum_x < 0) begin
            x_next = '0;
        end else if (sum_x >= SUM_W'(CANVAS_W)) begin
            x_next = XW'(CANVAS_W - 1);
        end else begin
            x_next = sum_x[XW-1:0];
        end
        if (sum_y < 0) begin
            y_next = '0;
        end else if (sum_y >= SUM_W'(CANVAS_H)) begin
            y_next = YW'(CANVAS_H - 1);
        end else begin
            y_next = sum_y[YW-1:0];
        end
    end

    // quotient estimate by reciprocal, low by at most one
    assign x_prod = (XW+RW)'(st1_x_reg) * (XW+RW)'(RECIP);
    assign y_prod = (YW+RW)'(st1_y_reg) * (YW+RW)'(RECIP);

    always_comb begin
        x_base   = XW'(st2_qx_reg) * XW'(CELL_SCALE);
        y_base   = YW'(st2_qy_reg) * YW'(CELL_SCALE);
        x_rem    = st2_x_reg - x_base;
        y_rem    = st2_y_reg - y_base;
        col_next = (x_rem >= XW'(CELL_SCALE)) ? st2_qx_reg + 1'b1 : st2_qx_reg;
        qy_next  = (y_rem >= YW'(CELL_SCALE)) ? st2_qy_reg + 1'b1 : st2_qy_reg;
    end

    always_comb begin
        row_scr    = ROW_W'(SCREEN_ROWS - 1) - st3_qy_reg;
        on_palette = (int'(st3_col_reg) < PAL_COLS) && (int'(row_scr) >= PAL_ROW0);
        cell_addr  = ADDR_W'(row_scr) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(st3_col_reg);
        color_next = color_reg;
        if (st3_left_reg && on_palette) begin
            color_next = swatch_of(COL_MAX_W'(st3_col_reg), SWATCH_WIDTH);
        end
        q_wr.push      = st3_valid_reg && !q_full;
        q_wr.cmd.addr  = ADDR_MAX_W'(cell_addr);
        q_wr.cmd.col   = COL_MAX_W'(st3_col_reg);
        q_wr.cmd.row   = ROW_MAX_W'(row_scr);
        q_wr.cmd.color = color_next;
        q_wr.cmd.left  = st3_left_reg;
        q_wr.cmd.paint = (st3_left_reg || st3_right_reg) && !on_palette;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg     <= SPEED_W'(1);
            x_reg         <= X_RESET;
            y_reg         <= Y_RESET;
            color_reg     <= PAINT_COLOR_RESET;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                speed_reg <= cfg_data;
            end
            if (load) begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            if (advance) begin
                st1_valid_reg <= load;
                st2_valid_reg <= st1_valid_reg;
                st3_valid_reg <= st2_valid_reg;
            end
            if (q_wr.push) begin
                color_reg <= color_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_left_reg  <= s_data.packet_flags[FLAG_LEFT];
            st1_right_reg <= s_data.packet_flags[FLAG_RIGHT];
            st1_x_reg     <= x_next;
            st1_y_reg     <= y_next;
            st2_left_reg  <= st1_left_reg;
            st2_right_reg <= st1_right_reg;
            st2_x_reg     <= st1_x_reg;
            st2_y_reg     <= st1_y_reg;
            st2_qx_reg    <= x_prod[SH +: COL_W];
            st2_qy_reg    <= y_prod[SH +: ROW_W];
            st3_left_reg  <= st2_left_reg;
            st3_right_reg <= st2_right_reg;
            st3_col_reg   <= col_next;
            st3_qy_reg    <= qy_next;
        end
    end

endmodule

### sv/mcpe_queue.sv
// Short command queue between the front end and the attribute writer.
// Depends on mcpe_pkg.
module mcpe_queue import mcpe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_push_t q_wr,
    output logic    q_full,
    output q_head_t q_head,
    input  logic    q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign q_full       = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign q_head.valid = count_reg != '0;
    assign q_head.cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (q_wr.push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (q_pop && !q_wr.push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            slot_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

endmodule

### sv/mcpe_back.sv
// Back end: attribute memory with its clearing pass, read-modify-write sequencer
// and result register. Depends on mcpe_pkg.
module mcpe_back import mcpe_pkg::*; #(
    parameter int SCREEN_COLUMNS  = DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS     = DEF_SCREEN_ROWS,
    parameter int CELL_SCALE      = DEF_CELL_SCALE,
    parameter int SWATCH_WIDTH    = DEF_SWATCH_WIDTH,
    parameter int PALETTE_ROWS    = DEF_PALETTE_ROWS,
    parameter int DARK_BACKGROUND = DEF_DARK_BACKGROUND
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  q_head_t      q_head,
    output logic         q_pop,
    output logic         clear_done,
    output logic         m_valid,
    input  logic         m_ready,
    output result_word_t m_data
);

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL0       = (SCREEN_COLUMNS * CELL_SCALE / 2) / CELL_SCALE;
    localparam int ROW0       = SCREEN_ROWS - 1 - (SCREEN_ROWS * CELL_SCALE / 2) / CELL_SCALE;
    localparam int PAL_COLS   = SWATCH_WIDTH * NUM_SWATCHES;
    localparam int PAL_ROW0   = SCREEN_ROWS - PALETTE_ROWS;

    localparam logic [ADDR_W-1:0] OLD_RESET = ADDR_W'(ROW0 * SCREEN_COLUMNS + COL0);
    localparam logic [2:0]        BG_COLOR  = (DARK_BACKGROUND != 0) ? 3'd0 : 3'd7;
    localparam logic              PLAIN_HL  = (DARK_BACKGROUND == 0);
    localparam logic              CURSOR_HL = (DARK_BACKGROUND != 0);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OLD,
        ST_NEW,
        ST_PAINT
    } state_t;

    logic [7:0] attr_mem [CELL_COUNT];

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] old_addr_reg, old_addr_next;
    logic [7:0]        hold_reg, hold_next;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0]  clr_col_reg, clr_col_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic              m_valid_reg, m_valid_next;
    result_word_t      m_data_reg, m_data_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;
    logic              out_free, same_cell, emit, emit_last, clr_pal;
    logic [ADDR_W-1:0] new_addr, emit_addr;
    logic [7:0]        v_old, v_new, v_paint, emit_value, clr_value;
    logic [2:0]        fill_color, clr_color;

    assign clear_done = state_reg != ST_CLEAR;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        new_addr   = q_head.cmd.addr[ADDR_W-1:0];
        same_cell  = new_addr == old_addr_reg;
        fill_color = q_head.cmd.left ? q_head.cmd.color : BG_COLOR;
        v_old      = with_highlight(rd_data_reg, PLAIN_HL);
        v_new      = with_highlight(same_cell ? hold_reg : rd_data_reg, CURSOR_HL);
        v_paint    = with_color(hold_reg, fill_color);

        clr_pal   = (int'(clr_col_reg) < PAL_COLS) && (int'(clr_row_reg) >= PAL_ROW0);
        clr_color = clr_pal ? swatch_of(COL_MAX_W'(clr_col_reg), SWATCH_WIDTH) : BG_COLOR;
        clr_value = with_highlight(with_color(8'h00, clr_color), PLAIN_HL);
    end

    always_comb begin
        state_next    = state_reg;
        old_addr_next = old_addr_reg;
        hold_next     = hold_reg;
        clr_addr_next = clr_addr_reg;
        clr_col_next  = clr_col_reg;
        clr_row_next  = clr_row_reg;
        mem_we        = 1'b0;
        mem_waddr     = old_addr_reg;
        mem_wdata     = v_old;
        mem_re        = 1'b0;
        mem_raddr     = old_addr_reg;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_addr     = old_addr_reg;
        emit_value    = v_old;
        q_pop         = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = clr_value;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_col_reg == COL_W'(SCREEN_COLUMNS - 1)) begin
                    clr_col_next = '0;
                    clr_row_next = clr_row_reg + 1'b1;
                end else begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
                if (clr_addr_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_head.valid) begin
                    mem_re     = 1'b1;
                    mem_raddr  = old_addr_reg;
                    state_next = ST_OLD;
                end
            end
            ST_OLD: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    emit       = 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = new_addr;
                    hold_next  = v_old;
                    state_next = ST_NEW;
                end
            end
            ST_NEW: begin
                if (out_free) begin
                    mem_we        = 1'b1;
                    mem_waddr     = new_addr;
                    mem_wdata     = v_new;
                    emit          = 1'b1;
                    emit_last     = !q_head.cmd.paint;
                    emit_addr     = new_addr;
                    emit_value    = v_new;
                    hold_next     = v_new;
                    old_addr_next = new_addr;
                    if (q_head.cmd.paint) begin
                        state_next = ST_PAINT;
                    end else begin
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAINT: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = new_addr;
                    mem_wdata  = v_paint;
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_addr  = new_addr;
                    emit_value = v_paint;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_data_next                 = m_data_reg;
        m_data_next.cell_address    = CELL_ADDR_W'(emit_addr);
        m_data_next.attribute_value = emit_value;
        m_data_next.last_write      = emit_last;
        m_data_next.cursor_column   = COL_OUT_W'(q_head.cmd.col);
        m_data_next.cursor_row      = ROW_OUT_W'(q_head.cmd.row);
        m_data_next.chosen_color    = q_head.cmd.color;
        m_valid_next                = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            old_addr_reg <= OLD_RESET;
            clr_addr_reg <= '0;
            clr_col_reg  <= '0;
            clr_row_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            old_addr_reg <= old_addr_next;
            clr_addr_reg <= clr_addr_next;
            clr_col_reg  <= clr_col_next;
            clr_row_reg  <= clr_row_next;
            m_valid_reg  <= m_valid_next;
        end
        hold_reg <= hold_next;
        if (emit) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            attr_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= attr_mem[mem_raddr];
        end
    end

endmodule

### sv/mouse_cursor_paint_engine.sv
// Top level of the mouse cursor paint engine: front end, command queue, back end.
// Depends on mcpe_pkg, mcpe_front, mcpe_queue and mcpe_back.
//
// Takes one three-byte mouse packet per s_ word and returns two or three attribute
// writes per packet on m_ (last_write marks the final one); packets with an overflow
// bit are consumed silently. After reset a clearing pass loads the attribute memory,
// SCREEN_COLUMNS*SCREEN_ROWS cells (2000 by default), during which s_ready is low; the
// speed register can be written at any time on cfg_. The front end takes a packet every
// cycle while the queue has room into a three-stage cursor and cell pipeline feeding a
// four-deep queue. The back end owns the single attribute memory, at most one read and
// one write of it per cycle, and steps through ST_IDLE, ST_OLD and ST_NEW for a packet
// that only moves the cursor, plus ST_PAINT for painting or erasing, a packet at a time.
module mouse_cursor_paint_engine import mcpe_pkg::*; #(
    parameter int SCREEN_COLUMNS  = DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS     = DEF_SCREEN_ROWS,
    parameter int CELL_SCALE      = DEF_CELL_SCALE,
    parameter int SWATCH_WIDTH    = DEF_SWATCH_WIDTH,
    parameter int PALETTE_ROWS    = DEF_PALETTE_ROWS,
    parameter int DARK_BACKGROUND = DEF_DARK_BACKGROUND
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SPEED_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  packet_word_t       s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output result_word_t       m_data
);

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;

    q_push_t q_wr;
    q_head_t q_head;
    logic    q_full, q_pop, clear_done;

    assign cfg_ready = 1'b1;

    mcpe_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .CELL_SCALE     (CELL_SCALE),
        .SWATCH_WIDTH   (SWATCH_WIDTH),
        .PALETTE_ROWS   (PALETTE_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .enable    (clear_done),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    mcpe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    mcpe_back #(
        .SCREEN_COLUMNS  (SCREEN_COLUMNS),
        .SCREEN_ROWS     (SCREEN_ROWS),
        .CELL_SCALE      (CELL_SCALE),
        .SWATCH_WIDTH    (SWATCH_WIDTH),
        .PALETTE_ROWS    (PALETTE_ROWS),
        .DARK_BACKGROUND (DARK_BACKGROUND)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // nothing leaves while the memory is still being cleared
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !m_valid)
        else $error("result word during clearing pass");

    // a packet's writes follow each other without a gap once one is taken
    a_writes_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_write |=> m_valid)
        else $error("gap inside a packet's write sequence");

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cell_address) < CELL_COUNT))
        else $error("cell address beyond the screen");

endmodule
